/* rtl/sdbc_pkg.sv */
package sdbc_pkg;

   localparam int unsigned REG_WIDTH       = 32;
   localparam int unsigned CSR_INDEX_WIDTH = 1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BUFFER_LENGTH = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FONT_START    = 1'b1;

   localparam int unsigned HEADER_BYTES = 12;
   localparam int unsigned COUNT_BYTE   = 4;
   localparam int unsigned RECORD_BYTES = 16;
   localparam int unsigned OFFSET_FIELD = 8;
   localparam int unsigned LENGTH_FIELD = 12;

   localparam logic [1:0] FAIL_NONE      = 2'd0;
   localparam logic [1:0] FAIL_HEADER    = 2'd1;
   localparam logic [1:0] FAIL_DIRECTORY = 2'd2;
   localparam logic [1:0] FAIL_EXTENT    = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
   } req_type;

   typedef struct packed {
      logic       verdict_ok;
      logic [1:0] fail_code;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type item;
   } verdict_type;

endpackage

/* rtl/sdbc_parse.sv */
module sdbc_parse #(
   parameter int unsigned POSITION_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  step,
   input  sdbc_pkg::req_type                     item,
   input  logic [sdbc_pkg::REG_WIDTH-1:0]        buffer_length,
   input  logic [sdbc_pkg::REG_WIDTH-1:0]        font_start,
   output sdbc_pkg::verdict_type                 verdict
);
   import sdbc_pkg::*;

   localparam int unsigned CW = (POSITION_WIDTH > REG_WIDTH) ? POSITION_WIDTH : REG_WIDTH;

   logic [POSITION_WIDTH-1:0] pos_ff, pos_in, pos_eff;
   logic [15:0]               count_ff, count_in, count_eff;
   logic [15:0]               index_ff, index_in, index_eff;
   logic [3:0]                rbyte_ff, rbyte_in, rbyte_eff;
   logic [31:0]               off_ff, off_in, off_eff;
   logic [31:0]               len_ff, len_in, len_eff;
   logic                      given_ff, given_in, given_eff;

   logic [CW-1:0] pos_ext, start_ext, rel;
   logic [32:0]   hdr_end, extent_sum;
   logic [33:0]   dir_end;
   logic [15:0]   count_new;
   logic [31:0]   off_new, len_new;
   logic [16:0]   index_next;

   always_comb begin
      pos_eff   = item.first_byte ? '0 : pos_ff;
      count_eff = item.first_byte ? '0 : count_ff;
      index_eff = item.first_byte ? '0 : index_ff;
      rbyte_eff = item.first_byte ? '0 : rbyte_ff;
      off_eff   = item.first_byte ? '0 : off_ff;
      len_eff   = item.first_byte ? '0 : len_ff;
      given_eff = item.first_byte ? 1'b0 : given_ff;

      pos_ext    = CW'(pos_eff);
      start_ext  = CW'(font_start);
      rel        = pos_ext - start_ext;
      hdr_end    = {1'b0, font_start} + 33'(HEADER_BYTES);
      count_new  = count_eff | {8'h00, item.data_byte};
      dir_end    = {2'b00, font_start} + 34'(HEADER_BYTES) + {14'b0, count_new, 4'b0000};
      off_new    = {off_eff[23:0], item.data_byte};
      len_new    = {len_eff[23:0], item.data_byte};
      extent_sum = {1'b0, off_eff} + {1'b0, len_new};
      index_next = {1'b0, index_eff} + 17'd1;

      pos_in    = pos_eff;
      count_in  = count_eff;
      index_in  = index_eff;
      rbyte_in  = rbyte_eff;
      off_in    = off_eff;
      len_in    = len_eff;
      given_in  = given_eff;
      verdict   = '0;

      if (step && !given_eff && pos_eff != '1) begin
         pos_in = pos_eff + 1'b1;
         if (pos_eff == '0 && hdr_end > {1'b0, buffer_length}) begin
            given_in               = 1'b1;
            verdict.valid          = 1'b1;
            verdict.item.fail_code = FAIL_HEADER;
         end else if (pos_ext >= start_ext) begin
            if (rel < CW'(HEADER_BYTES)) begin
               if (rel == CW'(COUNT_BYTE)) begin
                  count_in = {item.data_byte, 8'h00};
               end else if (rel == CW'(COUNT_BYTE + 1)) begin
                  count_in = count_new;
                  if (dir_end > {2'b00, buffer_length}) begin
                     given_in               = 1'b1;
                     verdict.valid          = 1'b1;
                     verdict.item.fail_code = FAIL_DIRECTORY;
                  end else if (count_new == '0) begin
                     given_in                = 1'b1;
                     verdict.valid           = 1'b1;
                     verdict.item.verdict_ok = 1'b1;
                     verdict.item.fail_code  = FAIL_NONE;
                  end
               end
            end else begin
               rbyte_in = rbyte_eff + 1'b1;
               if (rbyte_eff >= 4'(OFFSET_FIELD) && rbyte_eff < 4'(LENGTH_FIELD)) begin
                  off_in = off_new;
               end else if (rbyte_eff >= 4'(LENGTH_FIELD)) begin
                  len_in = len_new;
               end
               if (rbyte_eff == 4'(RECORD_BYTES - 1)) begin
                  index_in = index_next[15:0];
                  if (extent_sum > {1'b0, buffer_length}) begin
                     given_in               = 1'b1;
                     verdict.valid          = 1'b1;
                     verdict.item.fail_code = FAIL_EXTENT;
                  end else if (index_next >= {1'b0, count_eff}) begin
                     given_in                = 1'b1;
                     verdict.valid           = 1'b1;
                     verdict.item.verdict_ok = 1'b1;
                     verdict.item.fail_code  = FAIL_NONE;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         count_ff <= '0;
         index_ff <= '0;
         rbyte_ff <= '0;
         off_ff   <= '0;
         len_ff   <= '0;
         given_ff <= 1'b0;
      end else if (step) begin
         pos_ff   <= pos_in;
         count_ff <= count_in;
         index_ff <= index_in;
         rbyte_ff <= rbyte_in;
         off_ff   <= off_in;
         len_ff   <= len_in;
         given_ff <= given_in;
      end
   end

endmodule

/* rtl/sfnt_directory_bounds_check_top.sv */
// An accepted byte is held in the input register; the parse step takes it from there and loads
// its result into the result register, waiting while a finished result is stalled.
// Throughput: one byte per cycle, held back only while a finished result is stalled.
// Reset: synchronous, active high; clears both registers, the parse state and the
// valid flags of the input and result registers.
module sfnt_directory_bounds_check_top #(
   parameter int unsigned POSITION_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  sdbc_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output sdbc_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_write_enable,
   input  logic [sdbc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [sdbc_pkg::REG_WIDTH-1:0]        csr_write_data
);
   import sdbc_pkg::*;

   logic [REG_WIDTH-1:0] buffer_length_ff, font_start_ff;
   logic                 in_valid_ff, in_valid_in;
   req_type              in_item_ff;
   logic                 out_valid_ff, out_valid_in;
   rsp_type              out_item_ff;
   logic                 out_free, step;
   verdict_type          verdict;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_free ? (step && verdict.valid) : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_length_ff <= '0;
         font_start_ff    <= '0;
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_BUFFER_LENGTH: buffer_length_ff <= csr_write_data;
               CSR_FONT_START:    font_start_ff    <= csr_write_data;
               default: ;
            endcase
         end
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff <= req_data;
      end
      if (out_free && step && verdict.valid) begin
         out_item_ff <= verdict.item;
      end
   end

   sdbc_parse #(
      .POSITION_WIDTH(POSITION_WIDTH)
   ) u_parse (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .item          (in_item_ff),
      .buffer_length (buffer_length_ff),
      .font_start    (font_start_ff),
      .verdict       (verdict)
   );

endmodule

/* tb/tb.sv */
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sdbc_pkg::*;

   localparam int unsigned POS_WIDTH    = 32;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned ITEM_GOAL    = 850;
   localparam int unsigned BUFFER_GOAL  = 40;
   localparam int unsigned DRAIN_CYCLES = 4;
   localparam int unsigned REACH_LIMIT  = 64;

   logic                       clock            = 1'b0;
   logic                       reset            = 1'b1;
   logic                       req_valid        = 1'b0;
   logic                       req_stall;
   req_type                    req_data         = '0;
   logic                       rsp_valid;
   logic                       rsp_stall        = 1'b0;
   rsp_type                    rsp_data;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index        = CSR_BUFFER_LENGTH;
   logic [REG_WIDTH-1:0]       csr_write_data   = '0;

   sfnt_directory_bounds_check_top #(
      .POSITION_WIDTH(POS_WIDTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // Parser state mirrored by the testbench.
   logic [31:0]          reg_length;
   logic [31:0]          reg_start;
   logic [POS_WIDTH-1:0] next_pos;
   logic [15:0]          tbl_count;
   logic [15:0]          rec_num;
   logic [3:0]           rec_pos;
   logic [31:0]          off_shift;
   logic [31:0]          len_shift;
   bit                   verdict_done;

   rsp_type     expected_verdicts[$];
   req_type     byte_queue[$];
   logic        req_taken = 1'b0;
   logic [31:0] cycle_count = '0;
   int unsigned failures = 0;
   int unsigned bytes_taken = 0;
   int unsigned code_seen[4] = '{0, 0, 0, 0};
   int unsigned items_sent = 0;
   int unsigned buffers_sent = 0;
   int unsigned settings_used = 0;
   logic [31:0] gen_len = '0;
   logic [31:0] gen_start = '0;

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic clear_parse_state();
      next_pos     = '0;
      tbl_count    = '0;
      rec_num      = '0;
      rec_pos      = '0;
      off_shift    = '0;
      len_shift    = '0;
      verdict_done = 1'b0;
   endtask

   task automatic post_verdict(input logic [1:0] code);
      rsp_type v;
      v.verdict_ok = (code == FAIL_NONE);
      v.fail_code  = code;
      verdict_done = 1'b1;
      expected_verdicts.push_back(v);
   endtask

   task automatic parse_byte(input req_type item);
      longint unsigned here;
      longint unsigned start64;
      longint unsigned rel;
      longint unsigned span_end;
      int unsigned     done_recs;
      logic [3:0]      rb;
      if (item.first_byte) clear_parse_state();
      if (verdict_done || next_pos == {POS_WIDTH{1'b1}}) return;
      here = 64'(next_pos);
      next_pos = next_pos + 1'b1;
      start64 = 64'(reg_start);
      if (here == 0 && start64 + HEADER_BYTES > reg_length) begin
         post_verdict(FAIL_HEADER);
         return;
      end
      if (here < start64) return;
      rel = here - start64;
      if (rel < HEADER_BYTES) begin
         if (rel == COUNT_BYTE) begin
            tbl_count = {item.data_byte, 8'h00};
         end else if (rel == COUNT_BYTE + 1) begin
            tbl_count = tbl_count | {8'h00, item.data_byte};
            span_end = start64 + HEADER_BYTES + RECORD_BYTES * tbl_count;
            if (span_end > reg_length) post_verdict(FAIL_DIRECTORY);
            else if (tbl_count == 0) post_verdict(FAIL_NONE);
         end
         return;
      end
      rb = rec_pos;
      rec_pos = rec_pos + 1'b1;
      if (rb >= OFFSET_FIELD && rb < LENGTH_FIELD) off_shift = {off_shift[23:0], item.data_byte};
      else if (rb >= LENGTH_FIELD) len_shift = {len_shift[23:0], item.data_byte};
      if (rb == RECORD_BYTES - 1) begin
         span_end = 64'(off_shift);
         span_end += 64'(len_shift);
         done_recs = rec_num + 1;
         rec_num = rec_num + 1'b1;
         if (span_end > reg_length) post_verdict(FAIL_EXTENT);
         else if (done_recs >= tbl_count) post_verdict(FAIL_NONE);
      end
   endtask

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         reg_length = '0;
         reg_start  = '0;
         clear_parse_state();
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_BUFFER_LENGTH: reg_length = csr_write_data;
               CSR_FONT_START:    reg_start  = csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            bytes_taken++;
            parse_byte(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_verdicts.size() == 0) begin
               $error("unexpected verdict: verdict_ok %0b, fail_code %0d",
                      rsp_data.verdict_ok, rsp_data.fail_code);
               failures++;
            end else begin
               want = expected_verdicts.pop_front();
               code_seen[want.fail_code] += 1;
               if (rsp_data.verdict_ok !== want.verdict_ok) begin
                  $error("verdict_ok: expected %0b, got %0b",
                         want.verdict_ok, rsp_data.verdict_ok);
                  failures++;
               end
               if (rsp_data.fail_code !== want.fail_code) begin
                  $error("fail_code: expected %0d, got %0d",
                         want.fail_code, rsp_data.fail_code);
                  failures++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1'b1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("sfnt_directory_bounds_check_top: mismatch");
         $finish;
      end
   end

   always @(negedge clock) begin : sender
      static int unsigned burst_left = 1;
      static int unsigned gap_left = 0;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0 || byte_queue.size() == 0) begin
            req_valid <= 1'b0;
            if (gap_left > 0) gap_left--;
         end else begin
            req_valid <= 1'b1;
            req_data  <= byte_queue.pop_front();
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end
      end
   end

   always @(negedge clock) begin
      case (cycle_count[9:8])
         2'd1:    rsp_stall <= ($urandom_range(0, 2) == 0);
         2'd2:    rsp_stall <= (cycle_count[3:0] < 4'd11);
         default: rsp_stall <= 1'b0;
      endcase
   end

   task automatic send_byte(input logic [7:0] data, input logic first);
      req_type item;
      item.data_byte  = data;
      item.first_byte = first;
      byte_queue.push_back(item);
   endtask

   task automatic settle();
      while (byte_queue.size() != 0 || req_valid || expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_config(input logic [31:0] len, input logic [31:0] start);
      settle();
      if ($urandom_range(0, 1) == 0) begin
         write_reg(CSR_BUFFER_LENGTH, len);
         write_reg(CSR_FONT_START, start);
      end else begin
         write_reg(CSR_FONT_START, start);
         write_reg(CSR_BUFFER_LENGTH, len);
      end
      gen_len   = len;
      gen_start = start;
      settings_used++;
   endtask

   // Buffers starting within REACH_LIMIT stop at their deciding byte; a few are cut short on purpose.
   task automatic queue_buffer();
      logic [7:0]      body[$];
      logic [15:0]     cnt;
      logic [31:0]     off;
      logic [31:0]     len;
      longint unsigned dir_end;
      longint unsigned sum;
      int unsigned     pick;
      int unsigned     cap;
      int unsigned     cut;
      int unsigned     i;
      int              j;
      bit              truncated;
      pick = $urandom_range(0, 9);
      if (pick == 0) cnt = '0;
      else if (pick < 8) cnt = 16'($urandom_range(1, 3));
      else if (pick == 8) cnt = 16'($urandom_range(4, 7));
      else cnt = 16'($urandom_range(8, 16'hFFFF));
      dir_end = 64'(gen_start);
      dir_end += HEADER_BYTES + RECORD_BYTES * cnt;
      sum = 64'(gen_start);
      if (sum + HEADER_BYTES > gen_len) begin
         body.push_back(8'($urandom_range(0, 255)));
      end else if (gen_start > REACH_LIMIT) begin
         repeat ($urandom_range(1, 6)) body.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat (gen_start) body.push_back(8'($urandom_range(0, 255)));
         repeat (COUNT_BYTE) body.push_back(8'($urandom_range(0, 255)));
         body.push_back(cnt[15:8]);
         body.push_back(cnt[7:0]);
         if (dir_end <= gen_len && cnt != 0) begin
            repeat (HEADER_BYTES - COUNT_BYTE - 2) body.push_back(8'($urandom_range(0, 255)));
            cap = (cnt > 6) ? $urandom_range(1, 4) : cnt;
            for (i = 0; i < cap; i++) begin
               case ($urandom_range(0, 4))
                  0: begin
                     off = $urandom;
                     len = $urandom;
                  end
                  1: begin
                     off = $urandom_range(0, gen_len);
                     len = gen_len - off;
                  end
                  2: begin
                     off = $urandom_range(0, gen_len);
                     len = gen_len - off + 1;
                  end
                  3: begin
                     off = 32'hFFFF_FFFF;
                     len = $urandom_range(0, 1);
                  end
                  default: begin
                     off = $urandom_range(0, gen_len >> 1);
                     len = $urandom_range(0, gen_len >> 1);
                  end
               endcase
               if (i == cap - 1 && cap < cnt) begin
                  off = gen_len;
                  len = $urandom_range(1, 255);
               end
               repeat (OFFSET_FIELD) body.push_back(8'($urandom_range(0, 255)));
               for (j = 3; j >= 0; j--) body.push_back(off[8*j +: 8]);
               for (j = 3; j >= 0; j--) body.push_back(len[8*j +: 8]);
               sum = 64'(off);
               sum += 64'(len);
               if (sum > gen_len) break;
            end
         end
      end
      truncated = (body.size() > 1) && ($urandom_range(0, 11) == 0);
      if (truncated) begin
         cut = $urandom_range(1, body.size() - 1);
         while (body.size() > cut) void'(body.pop_back());
      end
      for (i = 0; i < body.size(); i++) send_byte(body[i], i == 0);
      items_sent += body.size();
      buffers_sent++;
      if (!truncated) begin
         repeat ($urandom_range(0, 3)) begin
            send_byte(8'($urandom_range(0, 255)), 1'b0);
            items_sent++;
         end
      end
   endtask

   initial begin : stimulus
      int unsigned phase;
      logic [31:0] len;
      logic [31:0] start;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // With registers at reset the header never fits; the flag is left low here.
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      set_config(32'hFFFF_FFFF, 32'h0000_0000);
      send_byte(8'h5A, 1'b1);
      send_byte(8'hA5, 1'b0);
      send_byte(8'h00, 1'b1);
      repeat (5) send_byte(8'h00, 1'b0);
      set_config(32'h000F_FFFB, 32'h0000_0000);
      send_byte(8'h12, 1'b1);
      repeat (3) send_byte(8'h34, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_byte(8'h00, 1'b1);
      items_sent = 17;

      while (items_sent < ITEM_GOAL || buffers_sent < BUFFER_GOAL) begin
         phase = $urandom_range(0, 9);
         start = $urandom_range(0, 6);
         case (phase)
            0: len = ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom_range(0, start + 11);
            1: len = 32'hFFFF_FFFF;
            2: begin
               start = $urandom_range(100, 32'hFFFF_FFF0);
               len   = 32'hFFFF_FFFF;
            end
            3: begin
               start = 32'hFFFF_FFFF;
               len   = $urandom;
            end
            default: len = start + HEADER_BYTES + RECORD_BYTES * $urandom_range(0, 4)
                           + $urandom_range(0, 2) - 1;
         endcase
         set_config(len, start);
         repeat ($urandom_range(2, 6)) begin
            if ($urandom_range(0, 9) == 0) begin
               repeat ($urandom_range(1, 12)) begin
                  send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                  items_sent++;
               end
            end else begin
               queue_buffer();
            end
         end
      end

      settle();
      $display("Streamed %0d bytes over %0d buffers and %0d register settings.",
               bytes_taken, buffers_sent, settings_used);
      $display("Verdicts checked: %0d ok, %0d header, %0d directory, %0d extent.",
               code_seen[FAIL_NONE], code_seen[FAIL_HEADER],
               code_seen[FAIL_DIRECTORY], code_seen[FAIL_EXTENT]);
      if (failures == 0) begin
         $display("sfnt_directory_bounds_check_top: match");
      end else begin
         $display("sfnt_directory_bounds_check_top: mismatch");
      end
      $finish;
   end

endmodule
